>>> src/dfc_pkg.sv
// ----------------------------------------------------------------------------
// dfc_pkg
// shared types, constants and constant tables of the decimal float16 codec
// ----------------------------------------------------------------------------
package dfc_pkg;

    localparam logic        REQ_ENCODE = 1'b0;
    localparam logic        REQ_DECODE = 1'b1;

    localparam logic [63:0] ENC_LIMIT  = 64'd8191000000;
    localparam logic [15:0] CODE_OVF   = 16'hffff;
    localparam logic [15:0] CODE_UNF   = 16'hfffe;
    localparam logic [63:0] DEC_OVF    = 64'hffffffffffffffff;
    localparam logic [63:0] DEC_UNF    = 64'hfffffffffffffffe;
    localparam logic [63:0] DEC_ERR    = 64'hfffffffffffffff0;
    localparam logic [2:0]  EXP_SPECIAL = 3'd7;
    localparam int          NUM_THR    = 6;

    typedef struct packed {
        logic        req_type;
        logic [63:0] int_value;
        logic [15:0] float_code;
    } dfc_in_t;

    typedef struct packed {
        logic [15:0] encoded_code;
        logic [63:0] decoded_value;
    } dfc_out_t;

    // after range classification
    typedef struct packed {
        logic        is_dec;
        logic        ovf;
        logic [2:0]  ex;
        logic [31:0] y;
        logic [15:0] code;
    } dfc_s1_t;

    // after reciprocal multiply and decode multiply
    typedef struct packed {
        logic        is_dec;
        logic        ovf;
        logic [2:0]  ex;
        logic [31:0] y;
        logic [12:0] q0;
        logic [63:0] dec_val;
    } dfc_s2_t;

    // after back multiply of the estimate
    typedef struct packed {
        logic        is_dec;
        logic        ovf;
        logic [2:0]  ex;
        logic [31:0] y;
        logic [12:0] q0;
        logic [26:0] back;
        logic [63:0] dec_val;
    } dfc_s3_t;

    // lower bound of each exponent step: 8192 * 10^k
    function automatic logic [63:0] enc_thr(input int k);
        case (k)
            0:       enc_thr = 64'd8192;
            1:       enc_thr = 64'd81920;
            2:       enc_thr = 64'd819200;
            3:       enc_thr = 64'd8192000;
            4:       enc_thr = 64'd81920000;
            default: enc_thr = 64'd819200000;
        endcase
    endfunction

    function automatic logic [13:0] pow5(input logic [2:0] e);
        case (e)
            3'd1:    pow5 = 14'd5;
            3'd2:    pow5 = 14'd25;
            3'd3:    pow5 = 14'd125;
            3'd4:    pow5 = 14'd625;
            3'd5:    pow5 = 14'd3125;
            3'd6:    pow5 = 14'd15625;
            default: pow5 = 14'd1;
        endcase
    endfunction

    // floor(2^32 / 5^e) for e = 1..6; zero for any other e
    function automatic logic [31:0] recip5(input logic [2:0] e);
        case (e)
            3'd1:    recip5 = 32'd858993459;
            3'd2:    recip5 = 32'd171798691;
            3'd3:    recip5 = 32'd34359738;
            3'd4:    recip5 = 32'd6871947;
            3'd5:    recip5 = 32'd1374389;
            3'd6:    recip5 = 32'd274877;
            default: recip5 = 32'd0;
        endcase
    endfunction

    function automatic logic [19:0] pow10(input logic [2:0] e);
        case (e)
            3'd0:    pow10 = 20'd1;
            3'd1:    pow10 = 20'd10;
            3'd2:    pow10 = 20'd100;
            3'd3:    pow10 = 20'd1000;
            3'd4:    pow10 = 20'd10000;
            3'd5:    pow10 = 20'd100000;
            3'd6:    pow10 = 20'd1000000;
            default: pow10 = 20'd0;
        endcase
    endfunction

endpackage

>>> src/decimal_float16_codec_core.sv
// ----------------------------------------------------------------------------
// decimal_float16_codec_core
// 64-bit unsigned integer <-> 16-bit decimal float (3-bit exponent, 13-bit
// significand) converter, four-stage pipeline
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | beat payload
//  --------+-----+--------------------+------------------------------------
//  s_      | in  | s_valid / s_ready  | req_type, int_value, float_code
//  m_      | out | m_valid / m_ready  | encoded_code, decoded_value
//
//  one beat in and one beat out per cycle while m_ready does not stall; an
//  accepted beat passes through the four register stages below, in order,
//  before m_valid rises with its result
//  aresetn (synchronous, active low) clears only the stage valid bits
//  a stage holds when the next one is full and stalled, so a stalled m_ready
//  backs up stage by stage; bubbles are filled while the output waits
//
module decimal_float16_codec_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dfc_pkg::dfc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output dfc_pkg::dfc_out_t m_data
);
    import dfc_pkg::*;

    // stage links
    logic     v1, v2, v3;
    logic     r2, r3, r4;
    dfc_s1_t  d1;
    dfc_s2_t  d2;
    dfc_s3_t  d3;

    // stage 1: overflow flag, exponent by threshold count, x >> e
    dfc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (v1),
        .out_ready (r2),
        .out_data  (d1)
    );

    // stage 2: quotient estimate by reciprocal of 5^e; decode multiply and
    // exponent-seven markers run alongside
    dfc_multiply u_multiply (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r2),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r3),
        .out_data  (d2)
    );

    // stage 3: estimate times divisor
    dfc_backmul u_backmul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r3),
        .in_data   (d2),
        .out_valid (v3),
        .out_ready (r4),
        .out_data  (d3)
    );

    // stage 4: one-step correction from the remainder, pack, output register
    dfc_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r4),
        .in_data   (d3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

>>> src/dfc_classify.sv
// ----------------------------------------------------------------------------
// dfc_classify
// stage 1: overflow check, exponent from thresholds, pre-shift by 2^e
// ----------------------------------------------------------------------------
module dfc_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dfc_pkg::dfc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dfc_pkg::dfc_s1_t  out_data
);
    import dfc_pkg::*;

    logic     valid_reg;
    dfc_s1_t  data_reg;
    dfc_s1_t  data_next;
    logic [2:0]  ex;
    logic [63:0] shifted;

    always_comb begin
        ex = 3'd0;
        for (int k = 0; k < NUM_THR; k++) begin
            if (in_data.int_value >= enc_thr(k)) begin
                ex = ex + 3'd1;
            end
        end
        // x / 10^e == (x >> e) / 5^e
        shifted = in_data.int_value >> ex;
        data_next.is_dec = (in_data.req_type == REQ_DECODE);
        data_next.ovf    = (in_data.int_value > ENC_LIMIT);
        data_next.ex     = ex;
        data_next.y      = shifted[31:0];
        data_next.code   = in_data.float_code;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/dfc_multiply.sv
// ----------------------------------------------------------------------------
// dfc_multiply
// stage 2: reciprocal quotient estimate and decode scaling
// ----------------------------------------------------------------------------
module dfc_multiply (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dfc_pkg::dfc_s1_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dfc_pkg::dfc_s2_t  out_data
);
    import dfc_pkg::*;

    logic     valid_reg;
    dfc_s2_t  data_reg;
    dfc_s2_t  data_next;
    logic [63:0] est;
    logic [2:0]  dec_ex;
    logic [12:0] mant;
    logic [32:0] scaled;

    always_comb begin
        est    = {32'd0, in_data.y} * {32'd0, recip5(in_data.ex)};
        dec_ex = in_data.code[15:13];
        mant   = in_data.code[12:0];
        scaled = 33'(mant) * 33'(pow10(dec_ex));

        data_next.is_dec = in_data.is_dec;
        data_next.ovf    = in_data.ovf;
        data_next.ex     = in_data.ex;
        data_next.y      = in_data.y;
        // estimate is low by at most one
        data_next.q0     = (in_data.ex == 3'd0) ? in_data.y[12:0] : est[44:32];
        if (dec_ex == EXP_SPECIAL) begin
            if (in_data.code == CODE_OVF) begin
                data_next.dec_val = DEC_OVF;
            end else if (in_data.code == CODE_UNF) begin
                data_next.dec_val = DEC_UNF;
            end else begin
                data_next.dec_val = DEC_ERR;
            end
        end else begin
            data_next.dec_val = {31'd0, scaled};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/dfc_backmul.sv
// ----------------------------------------------------------------------------
// dfc_backmul
// stage 3: multiplies the quotient estimate back by the divisor
// ----------------------------------------------------------------------------
module dfc_backmul (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dfc_pkg::dfc_s2_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dfc_pkg::dfc_s3_t  out_data
);
    import dfc_pkg::*;

    logic     valid_reg;
    dfc_s3_t  data_reg;
    dfc_s3_t  data_next;

    always_comb begin
        data_next.is_dec  = in_data.is_dec;
        data_next.ovf     = in_data.ovf;
        data_next.ex      = in_data.ex;
        data_next.y       = in_data.y;
        data_next.q0      = in_data.q0;
        data_next.back    = 27'(in_data.q0) * 27'(pow5(in_data.ex));
        data_next.dec_val = in_data.dec_val;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> src/dfc_finish.sv
// ----------------------------------------------------------------------------
// dfc_finish
// stage 4: remainder correction, code packing and output register
// ----------------------------------------------------------------------------
module dfc_finish (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  dfc_pkg::dfc_s3_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dfc_pkg::dfc_out_t out_data
);
    import dfc_pkg::*;

    logic      valid_reg;
    dfc_out_t  data_reg;
    dfc_out_t  data_next;
    logic [31:0] rem;
    logic [12:0] sig;

    always_comb begin
        rem = in_data.y - {5'd0, in_data.back};
        sig = (rem >= {18'd0, pow5(in_data.ex)}) ? (in_data.q0 + 13'd1) : in_data.q0;
        if (in_data.is_dec) begin
            data_next.encoded_code  = 16'd0;
            data_next.decoded_value = in_data.dec_val;
        end else begin
            data_next.encoded_code  = in_data.ovf ? CODE_OVF : {in_data.ex, sig};
            data_next.decoded_value = 64'd0;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
